[rtl/core/qhp_pkg.sv]
package qhp_pkg;

    typedef logic [3:0] phase_t;

    localparam phase_t PH_FIRST   = 4'd0;
    localparam phase_t PH_VERSION = 4'd1;
    localparam phase_t PH_DCIL    = 4'd2;
    localparam phase_t PH_DCID    = 4'd3;
    localparam phase_t PH_SCIL    = 4'd4;
    localparam phase_t PH_SCID    = 4'd5;
    localparam phase_t PH_TOKLEN  = 4'd6;
    localparam phase_t PH_TOKEN   = 4'd7;
    localparam phase_t PH_PAYLEN  = 4'd8;
    localparam phase_t PH_DONE    = 4'd9;
    localparam phase_t PH_SHORT   = 4'd10;
    localparam phase_t PH_ERR     = 4'd11;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TRUNCATED = 3'd1;
    localparam logic [2:0] ST_FIXED_BIT = 3'd2;
    localparam logic [2:0] ST_CID_LONG  = 3'd3;
    localparam logic [2:0] ST_OVERSIZE  = 3'd4;

    localparam logic [1:0] LT_INITIAL   = 2'd0;
    localparam logic [1:0] LT_RETRY     = 2'd3;
    localparam logic [2:0] KIND_SHORT   = 3'd4;

    localparam logic [16:0] END_SAT          = 17'h1FFFF;
    localparam logic [16:0] VERSION_END      = 17'd5;
    localparam logic [15:0] LONG_MIN_LEN     = 16'd7;
    localparam logic [4:0]  SHORT_DCID_RESET = 5'd8;

endpackage

[rtl/core/quic_header_parser.sv]
// Parses the header of a QUIC packet presented one byte per request, with
// last_byte set on the final byte, and gives one result per packet. A byte
// can be accepted in every clock cycle: each byte updates the registered parse
// state when accepted, and the result is registered and appears in the cycle
// after the last byte is accepted. While a result waits and out_ready is low, no
// byte is accepted; with out_ready high the result is taken and the next
// byte accepted in the same cycle. short_dcid_len may be written only
// between packets.
module quic_header_parser
    import qhp_pkg::*;
#(
    parameter int MAX_CID_LEN    = 20,
    parameter int MAX_PACKET_LEN = 65535
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [2:0]  packet_kind,
    output logic [4:0]  dest_cid_len,
    output logic [4:0]  src_cid_len,
    output logic [15:0] header_length
);

    localparam int CidW = $clog2(MAX_CID_LEN + 1);

    logic [15:0]     pos_reg, pos_next;
    phase_t          phase_reg, phase_next;
    logic [1:0]      type_reg, type_next;
    logic [CidW-1:0] dcid_reg, dcid_next;
    logic [CidW-1:0] scid_reg, scid_next;
    logic [16:0]     vlo_reg, vlo_next;
    logic            vbig_reg, vbig_next;
    logic [2:0]      vleft_reg, vleft_next;
    logic [16:0]     fend_reg, fend_next;
    logic [2:0]      err_reg, err_next;
    logic [4:0]      sdl_reg;

    logic            out_valid_reg;
    logic [2:0]      status_reg, status_next;
    logic [2:0]      kind_reg, kind_next;
    logic [4:0]      dlen_reg, dlen_next;
    logic [4:0]      slen_reg, slen_next;
    logic [15:0]     hlen_reg, hlen_next;

    logic            accept;
    logic            oversize;
    logic [15:0]     np;
    logic            v_done;
    logic [17:0]     tok_sum;
    logic [16:0]     tok_end;
    logic [15:0]     short_len;
    logic [CidW+4:0] dcid_ext;
    logic [CidW+4:0] scid_ext;

    function automatic phase_t after_scid(input logic [1:0] t);
        phase_t p;
        begin
            if (t == LT_RETRY) begin
                p = PH_DONE;
            end
            else if (t == LT_INITIAL) begin
                p = PH_TOKLEN;
            end
            else begin
                p = PH_PAYLEN;
            end
            return p;
        end
    endfunction

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign oversize = pos_reg >= 16'(MAX_PACKET_LEN);
    assign np       = oversize ? pos_reg : pos_reg + 16'd1;

    // Varint byte: the value is kept to 17 bits with a sticky flag for more.
    always_comb
    begin
        if (vleft_reg == 3'd0) begin
            vlo_next   = {11'd0, data_byte[5:0]};
            vbig_next  = 1'b0;
            vleft_next = 3'((4'd1 << data_byte[7:6]) - 4'd1);
            v_done     = data_byte[7:6] == 2'd0;
        end
        else begin
            vlo_next   = {vlo_reg[8:0], data_byte};
            vbig_next  = vbig_reg || (vlo_reg[16:9] != 8'd0);
            vleft_next = vleft_reg - 3'd1;
            v_done     = vleft_reg == 3'd1;
        end
    end

    assign tok_sum = {2'b00, np} + {1'b0, vlo_next};
    assign tok_end = (vbig_next || tok_sum > {1'b0, END_SAT}) ? END_SAT : tok_sum[16:0];

    always_comb
    begin
        phase_next = phase_reg;
        type_next  = type_reg;
        dcid_next  = dcid_reg;
        scid_next  = scid_reg;
        fend_next  = fend_reg;
        err_next   = err_reg;
        pos_next   = np;
        if (oversize) begin
            err_next   = ST_OVERSIZE;
            phase_next = PH_ERR;
        end
        else begin
            case (phase_reg)
                PH_FIRST:
                begin
                    type_next = data_byte[5:4];
                    if (!data_byte[6]) begin
                        err_next   = ST_FIXED_BIT;
                        phase_next = PH_ERR;
                    end
                    else if (data_byte[7]) begin
                        phase_next = PH_VERSION;
                        fend_next  = VERSION_END;
                    end
                    else begin
                        phase_next = PH_SHORT;
                    end
                end
                PH_VERSION:
                begin
                    if ({1'b0, np} == fend_reg) begin
                        phase_next = PH_DCIL;
                    end
                end
                PH_DCID:
                begin
                    if ({1'b0, np} == fend_reg) begin
                        phase_next = PH_SCIL;
                    end
                end
                PH_SCID:
                begin
                    if ({1'b0, np} == fend_reg) begin
                        phase_next = after_scid(type_reg);
                    end
                end
                PH_TOKEN:
                begin
                    if ({1'b0, np} == fend_reg) begin
                        phase_next = PH_PAYLEN;
                    end
                end
                PH_DCIL:
                begin
                    if (data_byte > 8'(MAX_CID_LEN)) begin
                        err_next   = ST_CID_LONG;
                        phase_next = PH_ERR;
                    end
                    else begin
                        dcid_next  = CidW'(data_byte);
                        fend_next  = {1'b0, np} + {9'd0, data_byte};
                        phase_next = (data_byte == 8'd0) ? PH_SCIL : PH_DCID;
                    end
                end
                PH_SCIL:
                begin
                    if (data_byte > 8'(MAX_CID_LEN)) begin
                        err_next   = ST_CID_LONG;
                        phase_next = PH_ERR;
                    end
                    else begin
                        scid_next  = CidW'(data_byte);
                        fend_next  = {1'b0, np} + {9'd0, data_byte};
                        phase_next = (data_byte == 8'd0) ? after_scid(type_reg) : PH_SCID;
                    end
                end
                PH_TOKLEN:
                begin
                    if (v_done) begin
                        fend_next = tok_end;
                        if (vlo_next == 17'd0 && !vbig_next) begin
                            phase_next = PH_PAYLEN;
                        end
                        else begin
                            phase_next = PH_TOKEN;
                        end
                    end
                end
                PH_PAYLEN:
                begin
                    if (v_done) begin
                        fend_next  = {1'b0, np};
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign short_len = {11'd0, sdl_reg} + 16'd1;
    assign dcid_ext  = {5'd0, dcid_next};
    assign scid_ext  = {5'd0, scid_next};

    always_comb
    begin
        status_next = ST_OK;
        kind_next   = 3'd0;
        dlen_next   = 5'd0;
        slen_next   = 5'd0;
        hlen_next   = 16'd0;
        if (err_next == ST_OVERSIZE) begin
            status_next = ST_OVERSIZE;
        end
        else if (phase_next == PH_SHORT) begin
            if (np < short_len) begin
                status_next = ST_TRUNCATED;
            end
            else begin
                kind_next = KIND_SHORT;
                dlen_next = sdl_reg;
                hlen_next = short_len;
            end
        end
        else if (phase_next == PH_ERR) begin
            if (err_next == ST_CID_LONG && np < LONG_MIN_LEN) begin
                status_next = ST_TRUNCATED;
            end
            else begin
                status_next = err_next;
            end
        end
        else if (np < LONG_MIN_LEN || phase_next != PH_DONE) begin
            status_next = ST_TRUNCATED;
        end
        else begin
            kind_next = {1'b0, type_next};
            dlen_next = dcid_ext[4:0];
            slen_next = scid_ext[4:0];
            hlen_next = fend_next[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg   <= 16'd0;
            phase_reg <= PH_FIRST;
            type_reg  <= 2'd0;
            dcid_reg  <= '0;
            scid_reg  <= '0;
            vlo_reg   <= 17'd0;
            vbig_reg  <= 1'b0;
            vleft_reg <= 3'd0;
            fend_reg  <= 17'd0;
            err_reg   <= ST_OK;
        end
        else if (accept) begin
            if (last_byte) begin
                pos_reg   <= 16'd0;
                phase_reg <= PH_FIRST;
                type_reg  <= 2'd0;
                dcid_reg  <= '0;
                scid_reg  <= '0;
                vlo_reg   <= 17'd0;
                vbig_reg  <= 1'b0;
                vleft_reg <= 3'd0;
                fend_reg  <= 17'd0;
                err_reg   <= ST_OK;
            end
            else begin
                pos_reg   <= pos_next;
                phase_reg <= phase_next;
                type_reg  <= type_next;
                dcid_reg  <= dcid_next;
                scid_reg  <= scid_next;
                fend_reg  <= fend_next;
                err_reg   <= err_next;
                if (!oversize && (phase_reg == PH_TOKLEN || phase_reg == PH_PAYLEN)) begin
                    vlo_reg   <= vlo_next;
                    vbig_reg  <= vbig_next;
                    vleft_reg <= vleft_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sdl_reg <= SHORT_DCID_RESET;
        end
        else if (cfg_we) begin
            sdl_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && last_byte) begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_byte) begin
            status_reg <= status_next;
            kind_reg   <= kind_next;
            dlen_reg   <= dlen_next;
            slen_reg   <= slen_next;
            hlen_reg   <= hlen_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign packet_kind   = kind_reg;
    assign dest_cid_len  = dlen_reg;
    assign src_cid_len   = slen_reg;
    assign header_length = hlen_reg;

`ifndef SYNTHESIS
    a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_OK |->
            kind_reg == 3'd0 && dlen_reg == 5'd0 && slen_reg == 5'd0 && hlen_reg == 16'd0)
        else $error("Failed result carries non-zero fields.");

    a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> out_valid_reg)
        else $error("No result after the last byte of a packet.");

    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> phase_reg == PH_FIRST && pos_reg == 16'd0 && err_reg == ST_OK)
        else $error("Parse state not cleared after a packet.");

    a_short_no_scid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_OK && kind_reg == KIND_SHORT |-> slen_reg == 5'd0)
        else $error("Short header result reports a source connection id.");
`endif

endmodule

[tb/tb_quic_header_parser.sv]
`timescale 1ns / 100ps

module tb_quic_header_parser;
    import qhp_pkg::*;

    localparam int MAX_CID_LEN    = 20;
    localparam int MAX_PACKET_LEN = 65535;

    localparam logic [1:0] LT_ZERO_RTT  = 2'd1;
    localparam logic [1:0] LT_HANDSHAKE = 2'd2;

    typedef struct {
        bit [2:0]  status;
        bit [2:0]  kind;
        bit [4:0]  dest_len;
        bit [4:0]  src_len;
        bit [15:0] hdr_len;
    } hdr_result_t;

    class header_scoreboard;
        bit [4:0]    short_len;
        bit [15:0]   byte_pos;
        phase_t      phase;
        bit [7:0]    lead_byte;
        bit [4:0]    dcid_n;
        bit [4:0]    scid_n;
        bit [61:0]   vint;
        bit [3:0]    vint_left;
        bit [16:0]   skip_end;
        bit [2:0]    err;
        hdr_result_t pending_headers[$];
        int          mismatches;

        function new();
            short_len = SHORT_DCID_RESET;
            mismatches = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            byte_pos = 0;
            phase = PH_FIRST;
            lead_byte = 0;
            dcid_n = 0;
            scid_n = 0;
            vint = 0;
            vint_left = 0;
            skip_end = 0;
            err = ST_OK;
        endfunction

        function void abort(bit [2:0] code);
            err = code;
            phase = PH_ERR;
        endfunction

        function bit take_varint(bit [7:0] b);
            if (vint_left == 0)
            begin
                vint = 62'(b[5:0]);
                vint_left = 4'((1 << b[7:6]) - 1);
            end
            else
            begin
                vint = {vint[53:0], b};
                vint_left--;
            end
            return vint_left == 0;
        endfunction

        function void note_byte(bit [7:0] b, bit last);
            bit [16:0]   np;
            bit [63:0]   tok_end;
            hdr_result_t r;
            if (byte_pos >= MAX_PACKET_LEN)
            begin
                abort(ST_OVERSIZE);
                np = 17'(byte_pos);
            end
            else
            begin
                np = 17'(byte_pos) + 17'd1;
                byte_pos = np[15:0];
                case (phase)
                    PH_FIRST:
                    begin
                        lead_byte = b;
                        if (!b[6])
                            abort(ST_FIXED_BIT);
                        else if (b[7])
                        begin
                            phase = PH_VERSION;
                            skip_end = VERSION_END;
                        end
                        else
                            phase = PH_SHORT;
                    end
                    PH_DCIL:
                        if (b > MAX_CID_LEN)
                            abort(ST_CID_LONG);
                        else
                        begin
                            dcid_n = b[4:0];
                            skip_end = np + 17'(b);
                            phase = PH_DCID;
                        end
                    PH_SCIL:
                        if (b > MAX_CID_LEN)
                            abort(ST_CID_LONG);
                        else
                        begin
                            scid_n = b[4:0];
                            skip_end = np + 17'(b);
                            phase = PH_SCID;
                        end
                    PH_TOKLEN:
                        if (take_varint(b))
                        begin
                            tok_end = 64'(np) + 64'(vint);
                            skip_end = (tok_end > END_SAT) ? END_SAT : tok_end[16:0];
                            phase = PH_TOKEN;
                        end
                    PH_PAYLEN:
                        if (take_varint(b))
                        begin
                            skip_end = np;
                            phase = PH_DONE;
                        end
                    default: ;
                endcase
                // A skipped field that ends here leads to the next field's phase, or to PH_DONE for a Retry packet.
                if (np == skip_end)
                begin
                    case (phase)
                        PH_VERSION: phase = PH_DCIL;
                        PH_DCID:    phase = PH_SCIL;
                        PH_TOKEN:   phase = PH_PAYLEN;
                        PH_SCID:
                            if (lead_byte[5:4] == LT_RETRY)
                                phase = PH_DONE;
                            else if (lead_byte[5:4] == LT_INITIAL)
                                phase = PH_TOKLEN;
                            else
                                phase = PH_PAYLEN;
                        default: ;
                    endcase
                end
            end

            if (!last)
                return;

            r = '{default: 0};
            if (err == ST_OVERSIZE)
                r.status = ST_OVERSIZE;
            else if (phase == PH_SHORT)
            begin
                if (np < 1 + short_len)
                    r.status = ST_TRUNCATED;
                else
                begin
                    r.kind = KIND_SHORT;
                    r.dest_len = short_len;
                    r.hdr_len = 16'(1 + short_len);
                end
            end
            else if (phase == PH_ERR)
                r.status = (err == ST_CID_LONG && np < LONG_MIN_LEN) ? ST_TRUNCATED : err;
            else if (np < LONG_MIN_LEN || phase != PH_DONE)
                r.status = ST_TRUNCATED;
            else
            begin
                r.kind = {1'b0, lead_byte[5:4]};
                r.dest_len = dcid_n;
                r.src_len = scid_n;
                r.hdr_len = skip_end[15:0];
            end
            pending_headers.push_back(r);
            clear_packet();
        endfunction

        function void check_field(string name, logic [15:0] exp, logic [15:0] act);
            if (act !== exp)
            begin
                $error("%s: expected %0d, got %0d", name, exp, act);
                mismatches++;
            end
        endfunction

        function void check_result(logic [2:0] st, logic [2:0] kind, logic [4:0] dl,
                                   logic [4:0] sl, logic [15:0] hl);
            hdr_result_t exp;
            if (pending_headers.size() == 0)
            begin
                $error("header result with no packet outstanding: status %0d", st);
                mismatches++;
                return;
            end
            exp = pending_headers.pop_front();
            check_field("status", exp.status, st);
            check_field("packet_kind", exp.kind, kind);
            check_field("dest_cid_len", exp.dest_len, dl);
            check_field("src_cid_len", exp.src_len, sl);
            check_field("header_length", exp.hdr_len, hl);
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'd0;
    logic        last_byte = 1'b0;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_wdata = 5'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [2:0]  packet_kind;
    logic [4:0]  dest_cid_len;
    logic [4:0]  src_cid_len;
    logic [15:0] header_length;

    header_scoreboard sb = new();
    bit [7:0]         pkt_q[$];

    quic_header_parser #(
        .MAX_CID_LEN    (MAX_CID_LEN),
        .MAX_PACKET_LEN (MAX_PACKET_LEN)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .packet_kind   (packet_kind),
        .dest_cid_len  (dest_cid_len),
        .src_cid_len   (src_cid_len),
        .header_length (header_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void put_random(int n);
        repeat (n) pkt_q.push_back(8'($urandom));
    endfunction

    function automatic void put_varint(bit [61:0] v, bit [1:0] code);
        bit [63:0] w;
        bit [7:0]  b;
        int        n;
        w = 64'(v);
        n = 1 << code;
        for (int i = n - 1; i >= 0; i--)
        begin
            b = w[8*i +: 8];
            if (i == n - 1)
                b[7:6] = code;
            pkt_q.push_back(b);
        end
    endfunction

    function automatic void put_long(bit [1:0] lt, int dcil, int scil, bit [61:0] tok,
                                     bit [1:0] tok_code, bit [61:0] pay, bit [1:0] pay_code,
                                     int trailer);
        pkt_q.push_back({2'b11, lt, 4'($urandom)});
        put_random(4);
        pkt_q.push_back(8'(dcil));
        if (dcil <= MAX_CID_LEN)
            put_random(dcil);
        pkt_q.push_back(8'(scil));
        if (scil <= MAX_CID_LEN)
            put_random(scil);
        if (lt == LT_INITIAL)
        begin
            put_varint(tok, tok_code);
            if (tok <= 64)
                put_random(int'(tok));
        end
        if (lt != LT_RETRY)
            put_varint(pay, pay_code);
        put_random(trailer);
    endfunction

    function automatic void cut_packet();
        int keep;
        keep = $urandom_range(1, pkt_q.size());
        while (pkt_q.size() > keep)
            void'(pkt_q.pop_back());
    endfunction

    function automatic void gen_random_packet(int sl);
        int       r;
        int       over;
        bit [1:0] lt;
        r = $urandom_range(0, 99);
        lt = 2'($urandom_range(0, 3));
        over = $urandom_range(MAX_CID_LEN + 1, 255);
        if (r < 58)
        begin
            put_long(lt, $urandom_range(0, MAX_CID_LEN), $urandom_range(0, MAX_CID_LEN),
                     62'($urandom_range(0, 12)), 2'($urandom_range(0, 3)),
                     62'({$urandom, $urandom}), 2'($urandom_range(0, 3)),
                     $urandom_range(0, 6));
            if ($urandom_range(0, 4) == 0)
                cut_packet();
        end
        else if (r < 74)
        begin
            pkt_q.push_back({2'b01, 6'($urandom)});
            put_random($urandom_range(0, sl + 4));
        end
        else if (r < 82)
        begin
            if ($urandom_range(0, 1) == 0)
                put_long(lt, over, 0, 0, 0, 0, 0, $urandom_range(0, 4));
            else
                put_long(lt, $urandom_range(0, MAX_CID_LEN), over, 0, 0, 0, 0,
                         $urandom_range(0, 4));
            if ($urandom_range(0, 2) == 0)
                cut_packet();
        end
        else if (r < 88)
        begin
            pkt_q.push_back({1'($urandom), 1'b0, 6'($urandom)});
            put_random($urandom_range(0, 8));
        end
        else if (r < 91)
            put_long(LT_INITIAL, $urandom_range(0, MAX_CID_LEN), $urandom_range(0, MAX_CID_LEN),
                     62'({$urandom, $urandom}), 2'd3, 0, 0, $urandom_range(0, 8));
        else
            put_random($urandom_range(1, 24));
    endfunction

    // Each byte is one request; a gap of random length may come before it unless the packet
    // goes out as a burst.
    task automatic send_packet();
        bit burst;
        int gap;
        int r;
        burst = ($urandom_range(0, 3) == 0);
        foreach (pkt_q[i])
        begin
            r = $urandom_range(0, 99);
            gap = (burst || r < 75) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 25);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            data_byte <= pkt_q[i];
            last_byte <= (i == pkt_q.size() - 1);
            @(negedge clk);
            while (!in_ready)
                @(negedge clk);
            @(posedge clk);
            sb.note_byte(pkt_q[i], i == pkt_q.size() - 1);
        end
        pkt_q.delete();
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending_headers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_short_len(bit [4:0] v);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.short_len = v;
    endtask

    initial
    begin
        int mode;
        int hold;
        hold = 0;
        forever
        begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(20, 120))
            begin
                @(posedge clk);
                if (hold > 0)
                    hold--;
                else if (mode == 0)
                    out_ready <= 1'b1;
                else if (mode == 1)
                    out_ready <= 1'($urandom_range(0, 1));
                else if ($urandom_range(0, 19) == 0)
                begin
                    out_ready <= 1'b0;
                    hold = $urandom_range(10, 40);
                end
                else
                    out_ready <= 1'b1;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(status, packet_kind, dest_cid_len, src_cid_len, header_length);
    end

    initial
    begin
        int sent;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        pkt_q.push_back(8'h40);
        put_random(8);
        send_packet();
        pkt_q.push_back(8'h7F);
        put_random(7);
        send_packet();
        pkt_q.push_back(8'h00);
        send_packet();
        pkt_q.push_back(8'hBF);
        put_random(5);
        send_packet();
        pkt_q.push_back(8'hFF);
        send_packet();
        // A long header cut off at or before an overlong DCID length is still truncated.
        put_long(LT_HANDSHAKE, 255, 0, 0, 0, 0, 0, 0);
        cut_packet();
        while (pkt_q.size() > 6)
            void'(pkt_q.pop_back());
        send_packet();
        put_long(LT_HANDSHAKE, 255, 0, 0, 0, 0, 0, 0);
        send_packet();
        put_long(LT_INITIAL, 0, 0, 0, 0, 0, 0, 0);
        send_packet();
        put_long(LT_RETRY, MAX_CID_LEN, MAX_CID_LEN, 0, 0, 0, 0, 3);
        send_packet();
        put_long(LT_ZERO_RTT, MAX_CID_LEN, 0, 0, 0, 62'h3FFF_FFFF_FFFF_FFFF, 2'd3, 2);
        send_packet();
        put_long(LT_HANDSHAKE, 1, MAX_CID_LEN, 0, 0, 300, 2'd1, 30);
        send_packet();
        put_long(LT_INITIAL, MAX_CID_LEN, MAX_CID_LEN, 63, 2'd0, 9, 2'd0, 1);
        send_packet();
        put_long(LT_INITIAL, 8, 8, 62'h3FFF_FFFF_FFFF_FFFF, 2'd3, 0, 0, 4);
        send_packet();
        put_long(LT_INITIAL, 3, 3, 5, 2'd2, 100, 2'd2, 0);
        void'(pkt_q.pop_back());
        void'(pkt_q.pop_back());
        send_packet();
        put_long(LT_HANDSHAKE, 4, MAX_CID_LEN + 1, 0, 0, 0, 0, 2);
        send_packet();
        put_long(LT_ZERO_RTT, MAX_CID_LEN + 1, 0, 0, 0, 0, 0, 2);
        send_packet();

        for (int p = 0; p < 7; p++)
        begin
            write_short_len((p == 0) ? 5'd0 : (p == 1) ? 5'd20 : 5'($urandom_range(0, 20)));
            sent = 0;
            while (sent < 190)
            begin
                gen_random_packet(sb.short_len);
                sent += pkt_q.size();
                send_packet();
            end
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_headers.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
